FILE: design/apba_pkg.sv
package apba_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int WORD_W     = 64;
  localparam int NWORDS     = POOL_DEPTH / WORD_W;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int WIDX_W     = $clog2(NWORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int LEN_W      = SLOT_W + 1;
  localparam int ADDR_W     = 32;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_REINIT  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN = 1'd1;

  localparam logic [LEN_W-1:0] PLEN_RESET = LEN_W'(POOL_DEPTH);

  typedef enum logic [1:0] {
    K_ALLOC,
    K_RELEASE,
    K_REINIT,
    K_REPLY
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [ST_W-1:0]   status;
  } cmd_t;

  // pool length clamped to 1 .. POOL_DEPTH
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] plen);
    logic [LEN_W-1:0] res;
    res = plen;
    if (plen == '0) begin
      res = LEN_W'(1);
    end else if (plen > LEN_W'(POOL_DEPTH)) begin
      res = LEN_W'(POOL_DEPTH);
    end
    return res;
  endfunction

endpackage

FILE: design/apba_front.sv
module apba_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [apba_pkg::OP_W-1:0]      in_operation,
  input  logic [apba_pkg::ADDR_W-1:0]    in_release_address,
  input  logic [apba_pkg::ADDR_W-1:0]    base_address,
  input  logic [apba_pkg::LEN_W-1:0]     pool_length,
  output logic                           push_valid,
  input  logic                           push_ready,
  output apba_pkg::cmd_t                 push_cmd
);
  import apba_pkg::*;

  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] off;

  assign len        = eff_len(pool_length);
  assign off        = in_release_address - base_address;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_cmd.kind   = K_REPLY;
    push_cmd.slot   = off[SLOT_W-1:0];
    push_cmd.status = ST_OK;
    unique case (in_operation)
      OP_ALLOC: begin
        push_cmd.kind = K_ALLOC;
      end
      OP_RELEASE: begin
        // range and zero checks settle here, the back only clears the bit
        if (in_release_address == '0) begin
          push_cmd.status = ST_ZERO;
        end else if (off >= ADDR_W'(len)) begin
          push_cmd.status = ST_RANGE;
        end else begin
          push_cmd.kind = K_RELEASE;
        end
      end
      OP_REINIT: begin
        push_cmd.kind = K_REINIT;
      end
      default: begin
        push_cmd.kind = K_REPLY;
      end
    endcase
  end

endmodule

FILE: design/apba_queue.sv
module apba_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  apba_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output apba_pkg::cmd_t pop_cmd
);
  import apba_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: design/apba_back.sv
module apba_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [apba_pkg::ADDR_W-1:0] base_address,
  input  logic [apba_pkg::LEN_W-1:0]  pool_length,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  apba_pkg::cmd_t              cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [apba_pkg::ADDR_W-1:0] out_granted_address,
  output logic [apba_pkg::ST_W-1:0]   out_status
);
  import apba_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MOD,
    B_SCAN,
    B_INIT
  } bstate_t;

  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};
  localparam int CNT_W = $clog2(SLOT_W);

  bstate_t             state_r, state_nxt;
  logic [SLOT_W-1:0]   hint_r, hint_nxt;
  logic [SLOT_W-1:0]   start_r, start_nxt;
  logic [WIDX_W-1:0]   widx_r, widx_nxt;
  logic                phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [ST_W-1:0]     out_st_r, out_st_nxt;

  logic [WORD_W-1:0]   map_r [NWORDS];
  logic [NWORDS-1:0]   wvalid_r;

  logic [LEN_W-1:0]    len;
  logic [SLOT_W-1:0]   len_m1;
  logic                out_free;
  logic [WIDX_W-1:0]   rd_idx;
  logic [WORD_W-1:0]   rd_word;
  logic [WORD_W-1:0]   ge_start;
  logic [WORD_W-1:0]   le_len;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   cand;
  logic                hit;
  logic [BIT_W-1:0]    enc;
  logic [SLOT_W-1:0]   pos;
  logic [WORD_W-1:0]   resv;
  logic [LEN_W:0]      mod_tmp;
  logic                wr_en;
  logic [WIDX_W-1:0]   wr_idx;
  logic [WORD_W-1:0]   wr_data;

  assign len      = eff_len(pool_length);
  assign len_m1   = SLOT_W'(len - LEN_W'(1));
  assign out_free = !out_valid_r || out_ready;

  assign rd_idx  = (state_r == B_SCAN) ? widx_r : cmd.slot[SLOT_W-1 -: WIDX_W];
  assign rd_word = wvalid_r[rd_idx] ? map_r[rd_idx] : '0;

  // window of the scan inside the current word
  assign ge_start = ONES << start_r[BIT_W-1:0];
  assign le_len   = ONES >> (BIT_W'(WORD_W - 1) - len_m1[BIT_W-1:0]);

  always_comb begin
    if (!phase_r) begin
      mask = ((widx_r == start_r[SLOT_W-1 -: WIDX_W]) ? ge_start : ONES) &
             ((widx_r == len_m1[SLOT_W-1 -: WIDX_W]) ? le_len : ONES);
    end else begin
      mask = (widx_r == start_r[SLOT_W-1 -: WIDX_W]) ? ~ge_start : ONES;
    end
  end

  assign cand = ~rd_word & mask;
  assign hit  = |cand;

  always_comb begin
    enc = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        enc = BIT_W'(j);
      end
    end
  end

  assign pos = {widx_r, enc};

  // reserved pattern: low byte 0, 1 or 255, only inside the pool
  always_comb begin
    logic [SLOT_W-1:0] p;
    logic [7:0]        low;
    for (int j = 0; j < WORD_W; j++) begin
      p       = {widx_r, BIT_W'(j)};
      low     = base_address[7:0] + 8'(p);
      resv[j] = (p <= len_m1) && (low == 8'h00 || low == 8'h01 || low == 8'hFF);
    end
  end

  assign mod_tmp = {rem_r, hint_r[cnt_r]};

  always_comb begin
    state_nxt     = state_r;
    hint_nxt      = hint_r;
    start_nxt     = start_r;
    widx_nxt      = widx_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    cmd_ready     = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = widx_r;
    wr_data       = rd_word;
    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            K_ALLOC: begin
              phase_nxt = 1'b0;
              if (LEN_W'(hint_r) >= len) begin
                // hint at or beyond the length: reduce it first, one bit a cycle
                rem_nxt   = '0;
                cnt_nxt   = CNT_W'(SLOT_W - 1);
                state_nxt = B_MOD;
              end else begin
                start_nxt = hint_r;
                widx_nxt  = hint_r[SLOT_W-1 -: WIDX_W];
                state_nxt = B_SCAN;
              end
            end
            K_RELEASE: begin
              wr_en         = 1'b1;
              wr_idx        = cmd.slot[SLOT_W-1 -: WIDX_W];
              wr_data       = rd_word & ~(WORD_W'(1) << cmd.slot[BIT_W-1:0]);
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_st_nxt    = ST_OK;
            end
            K_REINIT: begin
              widx_nxt  = '0;
              state_nxt = B_INIT;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_st_nxt    = cmd.status;
            end
          endcase
        end
      end
      B_MOD: begin
        if (mod_tmp >= {1'b0, len}) begin
          rem_nxt = LEN_W'(mod_tmp - {1'b0, len});
        end else begin
          rem_nxt = LEN_W'(mod_tmp);
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          start_nxt = rem_nxt[SLOT_W-1:0];
          widx_nxt  = rem_nxt[SLOT_W-1 -: WIDX_W];
          state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (hit) begin
          wr_en         = 1'b1;
          wr_idx        = widx_r;
          wr_data       = rd_word | (WORD_W'(1) << enc);
          hint_nxt      = (pos == len_m1) ? '0 : pos + SLOT_W'(1);
          out_valid_nxt = 1'b1;
          out_addr_nxt  = base_address + ADDR_W'(pos);
          out_st_nxt    = ST_OK;
          state_nxt     = B_IDLE;
        end else if (!phase_r) begin
          if (widx_r == len_m1[SLOT_W-1 -: WIDX_W]) begin
            phase_nxt = 1'b1;
            widx_nxt  = '0;
          end else begin
            widx_nxt = widx_r + WIDX_W'(1);
          end
        end else if (widx_r == start_r[SLOT_W-1 -: WIDX_W]) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_st_nxt    = ST_EXHAUSTED;
          state_nxt     = B_IDLE;
        end else begin
          widx_nxt = widx_r + WIDX_W'(1);
        end
      end
      B_INIT: begin
        wr_en   = 1'b1;
        wr_idx  = widx_r;
        wr_data = resv;
        if (widx_r == WIDX_W'(NWORDS - 1)) begin
          hint_nxt      = '0;
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_st_nxt    = ST_OK;
          state_nxt     = B_IDLE;
        end else begin
          widx_nxt = widx_r + WIDX_W'(1);
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      hint_r      <= '0;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      widx_r      <= '0;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      widx_r      <= widx_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      if (wr_en) begin
        wvalid_r[wr_idx] <= 1'b1;
      end
    end
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_st_r;

  // a multi-cycle operation only starts with the result register drained
  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> !out_valid_r)
    else $error("result pending while an operation is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_addr_r == $past(out_addr_r)) &&
                                     (out_st_r == $past(out_st_r)))
    else $error("stalled result overwritten");

  a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN && phase_r) |-> (widx_r <= start_r[SLOT_W-1 -: WIDX_W]))
    else $error("wrapped scan ran past the start word");

  a_hint_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN && hit) |=> (hint_r <= $past(len_m1)))
    else $error("search hint left the pool");

  a_mod_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MOD) |-> (cnt_r < CNT_W'(SLOT_W)))
    else $error("remainder step count out of range");

endmodule

FILE: design/address_pool_bitmap_allocator.sv
// channel  direction  beat contents                                  handshake
// in       input      in_operation, in_release_address             in_valid / in_ready
// out      output     out_granted_address, out_status              out_valid / out_ready
// cfg      input      cfg_index, cfg_data (0 base, 1 pool length)  cfg_wr_en
//
// release and unused codes: answered from the back end's idle state as they leave the queue.
// allocate: scans 64-slot words from the hint's word to the last pool word, then from word 0
//   up to the hint's word; a remainder step comes first when the hint is at or beyond the length.
// reinitialize: every 64-slot word rewritten, one word written per cycle.
// synchronous active-low reset: map reads as all free, hint zero, base 0, length 1024.
// a two-beat command queue and the output register let input and output stall apart.
module address_pool_bitmap_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [apba_pkg::OP_W-1:0]          in_operation,
  input  logic [apba_pkg::ADDR_W-1:0]        in_release_address,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [apba_pkg::ADDR_W-1:0]        out_granted_address,
  output logic [apba_pkg::ST_W-1:0]          out_status,
  input  logic                               cfg_wr_en,
  input  logic [apba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apba_pkg::ADDR_W-1:0]        cfg_data
);
  import apba_pkg::*;

  logic [ADDR_W-1:0] base_r;
  logic [LEN_W-1:0]  plen_r;
  logic              push_valid;
  logic              push_ready;
  cmd_t              push_cmd;
  logic              pop_valid;
  logic              pop_ready;
  cmd_t              pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      plen_r <= PLEN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE: base_r <= cfg_data;
        CFG_PLEN: plen_r <= cfg_data[LEN_W-1:0];
        default: begin
          base_r <= base_r;
        end
      endcase
    end
  end

  apba_front u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_release_address (in_release_address),
    .base_address       (base_r),
    .pool_length        (plen_r),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_cmd           (push_cmd)
  );

  apba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  apba_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .base_address        (base_r),
    .pool_length         (plen_r),
    .cmd_valid           (pop_valid),
    .cmd_ready           (pop_ready),
    .cmd                 (pop_cmd),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

endmodule
